[hdl/nfcs_pkg.sv]
`timescale 1ns / 1ps

package nfcs_pkg;

  // Input operation codes
  localparam logic [2:0] OP_RESET = 3'd0;
  localparam logic [2:0] OP_PROG  = 3'd1;
  localparam logic [2:0] OP_SECT  = 3'd2;
  localparam logic [2:0] OP_CHIP  = 3'd3;
  localparam logic [2:0] OP_IDENT = 3'd4;
  localparam logic [2:0] OP_READ  = 3'd5;

  // Result kinds
  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_REPORT = 2'd2;

  // Report status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_PROG_FAIL   = 3'd1;
  localparam logic [2:0] ST_ERASE_FAIL  = 3'd2;
  localparam logic [2:0] ST_ABSENT      = 3'd3;
  localparam logic [2:0] ST_LANE_FAULT  = 3'd4;
  localparam logic [2:0] ST_UNKNOWN     = 3'd5;
  localparam logic [2:0] ST_OTHER_MAKER = 3'd6;

  // Configuration register indexes
  localparam logic [1:0] CFG_FLASH_BASE = 2'd0;
  localparam logic [1:0] CFG_MAKER_ID   = 2'd1;
  localparam logic [1:0] CFG_BUS_WAIT   = 2'd2;

  // Bus constants
  localparam logic [31:0] ADR_A       = 32'h0001_5554;
  localparam logic [31:0] ADR_B       = 32'h0000_AAA8;
  localparam logic [31:0] D_AA        = 32'hAAAA_AAAA;
  localparam logic [31:0] D_55        = 32'h5555_5555;
  localparam logic [31:0] D_80        = 32'h8080_8080;
  localparam logic [31:0] C_RESET     = 32'hF0F0_F0F0;
  localparam logic [31:0] C_AUTOSEL   = 32'h9090_9090;
  localparam logic [31:0] C_PROGRAM   = 32'hA0A0_A0A0;
  localparam logic [31:0] C_CHIPERASE = 32'h1010_1010;
  localparam logic [31:0] C_SECERASE  = 32'h3030_3030;
  localparam logic [31:0] DEV_OFFSET  = 32'h0000_0004;

  localparam int OUT_W   = 88;
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_POLL,
    PH_IDMFG,
    PH_IDDEV
  } phase_t;

  typedef enum logic [2:0] {
    J_RESET,
    J_PROG,
    J_SECT,
    J_CHIP,
    J_IDENT,
    J_READ,
    J_REPORT
  } job_t;

  typedef struct packed {
    job_t        job;
    logic [31:0] addr;
    logic [31:0] data;
    logic [2:0]  status;
    logic [4:0]  idx;
    logic [7:0]  maker;
    logic [3:0]  mask;
  } job_entry_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] addr;
    logic [31:0] data;
    logic [2:0]  status;
    logic [4:0]  idx;
    logic [7:0]  maker;
    logic [3:0]  mask;
  } res_t;

  function automatic logic [7:0] dev_code(input logic [4:0] i);
    logic [7:0] c;
    case (i)
      5'd0:    c = 8'hA2;
      5'd1:    c = 8'h29;
      5'd2:    c = 8'h20;
      5'd3:    c = 8'hA4;
      5'd4:    c = 8'h2F;
      5'd5:    c = 8'hAE;
      5'd6:    c = 8'hA7;
      5'd7:    c = 8'h2A;
      5'd10:   c = 8'h51;
      5'd11:   c = 8'h57;
      5'd12:   c = 8'h23;
      5'd13:   c = 8'hAB;
      5'd14:   c = 8'hAD;
      5'd15:   c = 8'hA1;
      5'd16:   c = 8'h25;
      5'd17:   c = 8'hD5;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] job_len(input job_t j);
    logic [2:0] n;
    case (j)
      J_RESET: n = 3'd2;
      J_PROG:  n = 3'd5;
      J_SECT:  n = 3'd7;
      J_CHIP:  n = 3'd7;
      J_IDENT: n = 3'd4;
      default: n = 3'd1;
    endcase
    return n;
  endfunction

  function automatic res_t job_result(input job_entry_t e, input logic [2:0] step);
    res_t        r;
    logic [31:0] up;
    logic [31:0] ua;
    logic [31:0] ub;
    r  = '0;
    up = {e.addr[31:16], 16'h0000};
    ua = up | ADR_A;
    ub = up | ADR_B;
    r.kind = KIND_WRITE;
    case (e.job)
      J_RESET: begin
        if (step == 3'd0) begin
          r.addr = up;
          r.data = C_RESET;
        end else begin
          r.kind   = KIND_REPORT;
          r.addr   = e.addr;
          r.status = e.status;
        end
      end
      J_PROG: begin
        case (step)
          3'd0: begin r.addr = ua; r.data = D_AA; end
          3'd1: begin r.addr = ub; r.data = D_55; end
          3'd2: begin r.addr = ua; r.data = C_PROGRAM; end
          3'd3: begin r.addr = e.addr; r.data = e.data; end
          default: begin r.kind = KIND_READ; r.addr = e.addr; end
        endcase
      end
      J_SECT, J_CHIP: begin
        case (step)
          3'd0: begin r.addr = ua; r.data = D_AA; end
          3'd1: begin r.addr = ub; r.data = D_55; end
          3'd2: begin r.addr = ua; r.data = D_80; end
          3'd3: begin r.addr = ua; r.data = D_AA; end
          3'd4: begin r.addr = ub; r.data = D_55; end
          3'd5: begin
            if (e.job == J_SECT) begin
              r.addr = e.addr;
              r.data = C_SECERASE;
            end else begin
              r.addr = ua;
              r.data = C_CHIPERASE;
            end
          end
          default: begin r.kind = KIND_READ; r.addr = e.addr; end
        endcase
      end
      J_IDENT: begin
        case (step)
          3'd0: begin r.addr = ua; r.data = D_AA; end
          3'd1: begin r.addr = ub; r.data = D_55; end
          3'd2: begin r.addr = ua; r.data = C_AUTOSEL; end
          default: begin r.kind = KIND_READ; r.addr = e.addr; end
        endcase
      end
      J_READ: begin
        r.kind = KIND_READ;
        r.addr = e.addr;
      end
      default: begin
        r.kind   = KIND_REPORT;
        r.addr   = e.addr;
        r.status = e.status;
        r.idx    = e.idx;
        r.maker  = e.maker;
        r.mask   = e.mask;
      end
    endcase
    return r;
  endfunction

endpackage

[hdl/nfcs_front.sv]
`timescale 1ns / 1ps

module nfcs_front #(
  parameter int LANES      = 4,
  parameter int TYPE_COUNT = 18
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [63:0]         in_tdata,
  input  logic [2:0]          in_tuser,
  input  logic [31:0]         flash_base,
  input  logic [7:0]          maker_id,
  input  logic                q_full,
  output logic                push,
  output nfcs_pkg::job_entry_t entry
);
  import nfcs_pkg::*;

  logic        fire;
  logic [2:0]  op;
  logic [31:0] addr;
  logic [31:0] data;

  phase_t      phase_r, phase_nxt;
  logic [31:0] exp_r, exp_nxt;
  logic [31:0] poll_r, poll_nxt;
  logic [7:0]  saved_r, saved_nxt;
  logic [1:0]  fail_r, fail_nxt;

  logic        busy;
  logic        fail;
  logic        agree;
  logic        any_match;
  logic [3:0]  mask;
  logic [7:0]  b0;
  logic        found;
  logic [4:0]  found_idx;

  assign op        = in_tuser;
  assign addr      = in_tdata[31:0];
  assign data      = in_tdata[63:32];
  assign in_tready = !q_full;
  assign fire      = in_tvalid && in_tready;
  assign b0        = data[7:0];

  // Lane checks; lanes past the 32-bit word read as zero
  always_comb begin
    logic [63:0] dx;
    logic [63:0] ex;
    logic [7:0]  b;
    logic [7:0]  v;
    dx        = {32'h0, data};
    ex        = {32'h0, exp_r};
    busy      = 1'b0;
    fail      = 1'b0;
    agree     = 1'b1;
    any_match = 1'b0;
    mask      = '0;
    // walk down so the lowest busy lane wins
    for (int d = LANES - 1; d >= 0; d--) begin
      b = dx[8*d +: 8];
      v = ex[8*d +: 8];
      if (b[7] != v[7]) begin
        busy = 1'b1;
        fail = b[5];
      end
    end
    for (int d = 0; d < LANES; d++) begin
      b = dx[8*d +: 8];
      if (b != b0) agree = 1'b0;
      if (b == maker_id) any_match = 1'b1;
      else if (d < 4) mask[2'(d)] = 1'b1;
    end
  end

  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = TYPE_COUNT - 1; i >= 0; i--) begin
      if (dev_code(5'(i)) == data[7:0]) begin
        found     = 1'b1;
        found_idx = 5'(i);
      end
    end
  end

  // Next state
  always_comb begin
    phase_nxt = phase_r;
    exp_nxt   = exp_r;
    poll_nxt  = poll_r;
    saved_nxt = saved_r;
    fail_nxt  = fail_r;
    if (fire) begin
      case (op)
        OP_RESET: phase_nxt = PH_IDLE;
        OP_PROG: begin
          phase_nxt = PH_POLL;
          exp_nxt   = data;
          poll_nxt  = addr;
          fail_nxt  = 2'(ST_PROG_FAIL);
        end
        OP_SECT: begin
          phase_nxt = PH_POLL;
          exp_nxt   = D_80;
          poll_nxt  = addr;
          fail_nxt  = 2'(ST_ERASE_FAIL);
        end
        OP_CHIP: begin
          phase_nxt = PH_POLL;
          exp_nxt   = D_80;
          poll_nxt  = flash_base;
          fail_nxt  = 2'(ST_ERASE_FAIL);
        end
        OP_IDENT: phase_nxt = PH_IDMFG;
        OP_READ: begin
          case (phase_r)
            PH_POLL: begin
              if (!busy || fail) phase_nxt = PH_IDLE;
            end
            PH_IDMFG: begin
              saved_nxt = b0;
              phase_nxt = agree ? PH_IDDEV : PH_IDLE;
            end
            PH_IDDEV: phase_nxt = PH_IDLE;
            default:  phase_nxt = phase_r;
          endcase
        end
        default: phase_nxt = phase_r;
      endcase
    end
  end

  // Queue entry
  always_comb begin
    push  = 1'b0;
    entry = '0;
    entry.job  = J_REPORT;
    entry.addr = flash_base;
    case (op)
      OP_RESET: begin
        push      = fire;
        entry.job = J_RESET;
      end
      OP_PROG: begin
        push       = fire;
        entry.job  = J_PROG;
        entry.addr = addr;
        entry.data = data;
      end
      OP_SECT: begin
        push       = fire;
        entry.job  = J_SECT;
        entry.addr = addr;
      end
      OP_CHIP: begin
        push      = fire;
        entry.job = J_CHIP;
      end
      OP_IDENT: begin
        push      = fire;
        entry.job = J_IDENT;
      end
      OP_READ: begin
        case (phase_r)
          PH_POLL: begin
            push       = fire;
            entry.addr = poll_r;
            if (!busy) entry.status = ST_OK;
            else if (fail) entry.status = {1'b0, fail_r};
            else entry.job = J_READ;
          end
          PH_IDMFG: begin
            push        = fire;
            entry.maker = b0;
            if (agree) begin
              entry.job   = J_READ;
              entry.addr  = flash_base | DEV_OFFSET;
              entry.maker = '0;
            end else if (!any_match) begin
              entry.status = ST_ABSENT;
            end else begin
              entry.status = ST_LANE_FAULT;
              entry.mask   = mask;
            end
          end
          PH_IDDEV: begin
            push        = fire;
            entry.maker = saved_r;
            if (saved_r != maker_id) entry.status = ST_OTHER_MAKER;
            else if (found) entry.idx = found_idx;
            else entry.status = ST_UNKNOWN;
          end
          default: push = 1'b0;
        endcase
      end
      default: push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      exp_r   <= '0;
      poll_r  <= '0;
      saved_r <= '0;
      fail_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      exp_r   <= exp_nxt;
      poll_r  <= poll_nxt;
      saved_r <= saved_nxt;
      fail_r  <= fail_nxt;
    end
  end

endmodule

[hdl/nfcs_queue.sv]
`timescale 1ns / 1ps

module nfcs_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  nfcs_pkg::job_entry_t push_entry,
  input  logic                 pop,
  output logic                 q_valid,
  output logic                 q_full,
  output nfcs_pkg::job_entry_t q_entry
);
  import nfcs_pkg::*;

  job_entry_t          mem_r [Q_DEPTH];
  logic [Q_AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]       count_r, count_nxt;

  assign q_valid = count_r != '0;
  assign q_full  = count_r == (Q_AW + 1)'(Q_DEPTH);
  assign q_entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + Q_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + Q_AW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) count_nxt = count_r + (Q_AW + 1)'(1);
    else if (pop && !push) count_nxt = count_r - (Q_AW + 1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

endmodule

[hdl/nfcs_back.sv]
`timescale 1ns / 1ps

module nfcs_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [15:0]          bus_wait,
  input  logic                 q_valid,
  input  nfcs_pkg::job_entry_t q_entry,
  output logic                 pop,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [nfcs_pkg::OUT_W-1:0] out_tdata,
  output logic [1:0]           out_tuser,
  output logic                 out_tlast
);
  import nfcs_pkg::*;

  job_entry_t  cur_r, cur_nxt;
  logic        busy_r, busy_nxt;
  logic [2:0]  step_r, step_nxt;
  logic [15:0] wait_r, wait_nxt;
  logic        out_valid_r, out_valid_nxt;
  res_t        res;
  res_t        res_r;
  logic        last_r;
  logic        out_free;
  logic        emit;
  logic        last_step;

  assign res       = job_result(cur_r, step_r);
  assign out_free  = !out_valid_r || out_tready;
  assign emit      = busy_r && out_free && (wait_r == '0);
  assign last_step = step_r == job_len(cur_r.job) - 3'd1;
  assign pop       = q_valid && (!busy_r || (emit && last_step));

  always_comb begin
    cur_nxt  = pop ? q_entry : cur_r;
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (pop) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
    end else if (emit) begin
      busy_nxt = !last_step;
      step_nxt = step_r + 3'd1;
    end
    // hold off the next access for the settle time after a write
    wait_nxt = wait_r;
    if (emit && res.kind == KIND_WRITE) wait_nxt = bus_wait;
    else if (wait_r != '0) wait_nxt = wait_r - 16'd1;
    out_valid_nxt = emit ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= '0;
      wait_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      step_r      <= step_nxt;
      wait_r      <= wait_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (emit) begin
      res_r  <= res;
      last_r <= last_step;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.kind;
  assign out_tlast  = last_r;
  assign out_tdata  = {4'h0, res_r.mask, res_r.maker, res_r.idx, res_r.status,
                       res_r.data, res_r.addr};

endmodule

[hdl/nor_flash_command_sequencer_unit.sv]
`timescale 1ns / 1ps
// Channel | Dir | tdata (low bit up)                                  | tuser     | tlast
// in_     | in  | address[31:0], data[63:32]                          | operation | -
// out_    | out | bus_address, bus_data, status, device_index,        | kind      | last
//         |     | maker_code, lane_fault_mask, zero pad [87:84]       |           |
// cfg_    | in  | cfg_index selects flash_base, maker_id, bus_wait; cfg_wdata is the value
//
// A command is classified on acceptance and queued; the sequencer then emits its
// 1 to 7 bus cycles and reports at one per cycle while the output is not stalled,
// each write holding off the next access until the bus_wait count has run down.
// The four-entry job queue lets input transactions be taken while the sequencer
// or the output stalls.
// Reset is synchronous; no clearing pass is needed.

module nor_flash_command_sequencer_unit #(
  parameter int LANES      = 4,
  parameter int TYPE_COUNT = 18
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // address, data
  input  logic [2:0]  in_tuser,   // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // bus_address, bus_data, status, device_index,
                                  // maker_code, lane_fault_mask
  output logic [1:0]  out_tuser,  // kind
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import nfcs_pkg::*;

  logic [31:0] flash_base_r;
  logic [7:0]  maker_id_r;
  logic [15:0] bus_wait_r;
  logic        push;
  logic        pop;
  logic        q_valid;
  logic        q_full;
  job_entry_t  push_entry;
  job_entry_t  q_entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flash_base_r <= '0;
      maker_id_r   <= 8'h01;
      bus_wait_r   <= 16'd16;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FLASH_BASE: flash_base_r <= cfg_wdata;
        CFG_MAKER_ID:   maker_id_r   <= cfg_wdata[7:0];
        CFG_BUS_WAIT:   bus_wait_r   <= cfg_wdata[15:0];
        default:        flash_base_r <= flash_base_r;
      endcase
    end
  end

  nfcs_front #(
    .LANES      (LANES),
    .TYPE_COUNT (TYPE_COUNT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .flash_base (flash_base_r),
    .maker_id   (maker_id_r),
    .q_full     (q_full),
    .push       (push),
    .entry      (push_entry)
  );

  nfcs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_full     (q_full),
    .q_entry    (q_entry)
  );

  nfcs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .bus_wait   (bus_wait_r),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

[hdl/nfcs_checker.sv]
`timescale 1ns / 1ps

module nfcs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [87:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);
  import nfcs_pkg::*;

  // no result leaves in the cycle after reset
  a_quiet_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == KIND_WRITE || out_tuser == KIND_READ ||
                    out_tuser == KIND_REPORT))
    else $error("illegal result kind");

  // a report always closes the transaction it belongs to
  a_report_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_REPORT) |-> out_tlast)
    else $error("report without tlast");

  a_bus_cycle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != KIND_REPORT) |-> (out_tdata[87:64] == '0))
    else $error("report fields set on a bus cycle");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) &&
                                     $stable(out_tuser) && $stable(out_tlast)))
    else $error("stalled result changed");

endmodule

bind nor_flash_command_sequencer_unit nfcs_checker u_nfcs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import nfcs_pkg::*;

  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam int QUIET_LIMIT = 300000;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER  = 150;

  localparam logic [7:0] DEVICE_TYPE_CODES [0:17] = '{
    8'hA2, 8'h29, 8'h20, 8'hA4, 8'h2F, 8'hAE, 8'hA7, 8'h2A, 8'h00,
    8'h00, 8'h51, 8'h57, 8'h23, 8'hAB, 8'hAD, 8'hA1, 8'h25, 8'hD5
  };

  typedef enum {POLL_DONE, POLL_BUSY, POLL_FAIL} poll_mode_t;
  typedef enum {ID_MATCH, ID_FOREIGN, ID_SPLIT, ID_ABSENT} ident_style_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] adr;
    logic [31:0] dat;
    logic [2:0]  status;
    logic [4:0]  dev;
    logic [7:0]  maker;
    logic [3:0]  mask;
    logic        last;
  } bus_cycle_t;

  class flash_bus_scoreboard;
    logic [31:0] base;
    logic [7:0]  maker;
    phase_t      ph;
    logic [31:0] pattern;
    logic [31:0] poll_adr;
    logic [31:0] ident;
    logic [2:0]  fail_code;
    bus_cycle_t  due_cycles[$];
    bus_cycle_t  staged[$];
    int          errors;
    int          inputs;
    int          checked;

    function new();
      base      = '0;
      maker     = 8'h01;
      ph        = PH_IDLE;
      pattern   = '0;
      poll_adr  = '0;
      ident     = '0;
      fail_code = ST_OK;
      errors    = 0;
      inputs    = 0;
      checked   = 0;
    endfunction

    function void set_reg(input logic [1:0] idx, input logic [31:0] v);
      case (idx)
        CFG_FLASH_BASE: base = v;
        CFG_MAKER_ID:   maker = v[7:0];
        default: ;  // bus_wait only paces the bus
      endcase
    endfunction

    function void stage(input logic [1:0] kind, input logic [31:0] adr, input logic [31:0] dat,
                        input logic [2:0] st = ST_OK, input logic [4:0] dev = '0,
                        input logic [7:0] mk = '0, input logic [3:0] msk = '0);
      bus_cycle_t c;
      c.kind   = kind;
      c.adr    = adr;
      c.dat    = dat;
      c.status = st;
      c.dev    = dev;
      c.maker  = mk;
      c.mask   = msk;
      c.last   = 1'b0;
      staged.push_back(c);
    endfunction

    function void report(input logic [31:0] adr, input logic [2:0] st,
                         input logic [4:0] dev = '0, input logic [7:0] mk = '0,
                         input logic [3:0] msk = '0);
      ph = PH_IDLE;
      stage(KIND_REPORT, adr, '0, st, dev, mk, msk);
    endfunction

    function void unlock_erase(input logic [31:0] up);
      stage(KIND_WRITE, up | ADR_A, D_AA);
      stage(KIND_WRITE, up | ADR_B, D_55);
      stage(KIND_WRITE, up | ADR_A, D_80);
      stage(KIND_WRITE, up | ADR_A, D_AA);
      stage(KIND_WRITE, up | ADR_B, D_55);
    endfunction

    function void note_transaction(input logic [2:0] op, input logic [31:0] adr,
                                   input logic [31:0] dat);
      logic [31:0] up;
      logic        busy;
      logic        fail;
      logic        agree;
      logic        any;
      logic [3:0]  msk;
      int          found;
      int          d;
      bus_cycle_t  c;
      inputs++;
      case (op)
        OP_RESET: begin
          stage(KIND_WRITE, {base[31:16], 16'h0000}, C_RESET);
          report(base, ST_OK);
        end
        OP_PROG: begin
          up = {adr[31:16], 16'h0000};
          stage(KIND_WRITE, up | ADR_A, D_AA);
          stage(KIND_WRITE, up | ADR_B, D_55);
          stage(KIND_WRITE, up | ADR_A, C_PROGRAM);
          stage(KIND_WRITE, adr, dat);
          stage(KIND_READ, adr, '0);
          ph        = PH_POLL;
          pattern   = dat;
          poll_adr  = adr;
          fail_code = ST_PROG_FAIL;
        end
        OP_SECT: begin
          unlock_erase({adr[31:16], 16'h0000});
          stage(KIND_WRITE, adr, C_SECERASE);
          stage(KIND_READ, adr, '0);
          ph        = PH_POLL;
          pattern   = D_80;
          poll_adr  = adr;
          fail_code = ST_ERASE_FAIL;
        end
        OP_CHIP: begin
          up = {base[31:16], 16'h0000};
          unlock_erase(up);
          stage(KIND_WRITE, up | ADR_A, C_CHIPERASE);
          stage(KIND_READ, base, '0);
          ph        = PH_POLL;
          pattern   = D_80;
          poll_adr  = base;
          fail_code = ST_ERASE_FAIL;
        end
        OP_IDENT: begin
          up = {base[31:16], 16'h0000};
          stage(KIND_WRITE, up | ADR_A, D_AA);
          stage(KIND_WRITE, up | ADR_B, D_55);
          stage(KIND_WRITE, up | ADR_A, C_AUTOSEL);
          stage(KIND_READ, base, '0);
          ph = PH_IDMFG;
        end
        OP_READ: begin
          case (ph)
            PH_POLL: begin
              busy = 1'b0;
              fail = 1'b0;
              // the first lane whose DQ7 still differs decides
              for (d = 0; d < 4; d++) begin
                if (!busy && dat[8*d+7] != pattern[8*d+7]) begin
                  busy = 1'b1;
                  fail = dat[8*d+5];
                end
              end
              if (!busy) report(poll_adr, ST_OK);
              else if (fail) report(poll_adr, fail_code);
              else stage(KIND_READ, poll_adr, '0);
            end
            PH_IDMFG: begin
              ident = dat;
              agree = 1'b1;
              any   = 1'b0;
              msk   = '0;
              for (d = 0; d < 4; d++) begin
                if (dat[8*d +: 8] != dat[7:0]) agree = 1'b0;
                if (dat[8*d +: 8] == maker) any = 1'b1;
                else msk[d] = 1'b1;
              end
              if (agree) begin
                stage(KIND_READ, base | DEV_OFFSET, '0);
                ph = PH_IDDEV;
              end else if (!any) begin
                report(base, ST_ABSENT, '0, dat[7:0]);
              end else begin
                report(base, ST_LANE_FAULT, '0, dat[7:0], msk);
              end
            end
            PH_IDDEV: begin
              if (ident[7:0] != maker) begin
                report(base, ST_OTHER_MAKER, '0, ident[7:0]);
              end else begin
                found = -1;
                for (d = 0; d < 18; d++)
                  if (found < 0 && DEVICE_TYPE_CODES[d] == dat[7:0]) found = d;
                if (found >= 0) report(base, ST_OK, 5'(found), ident[7:0]);
                else report(base, ST_UNKNOWN, '0, ident[7:0]);
              end
            end
            default: ;  // drop read data while idle
          endcase
        end
        default: ;  // spare codes are dropped
      endcase
      if (staged.size() > 0) begin
        c = staged.pop_back();
        c.last = 1'b1;
        staged.push_back(c);
      end
      while (staged.size() > 0) due_cycles.push_back(staged.pop_front());
    endfunction

    function void compare(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
        errors++;
        $error("%s: expected %h, actual %h", name, want, got);
      end
    endfunction

    function void check_bus_cycle(input bus_cycle_t got);
      bus_cycle_t want;
      checked++;
      if (due_cycles.size() == 0) begin
        errors++;
        $error("unexpected bus cycle: kind %0d address %h", got.kind, got.adr);
        return;
      end
      want = due_cycles.pop_front();
      compare("kind", 32'(want.kind), 32'(got.kind));
      compare("bus_address", want.adr, got.adr);
      compare("bus_data", want.dat, got.dat);
      compare("status", 32'(want.status), 32'(got.status));
      compare("device_index", 32'(want.dev), 32'(got.dev));
      compare("maker_code", 32'(want.maker), 32'(got.maker));
      compare("lane_fault_mask", 32'(want.mask), 32'(got.mask));
      compare("last", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;
  logic [2:0]  in_tuser   = OP_RESET;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [87:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_index  = CFG_FLASH_BASE;
  logic [31:0] cfg_wdata  = '0;

  flash_bus_scoreboard sb = new();
  bus_cycle_t  seen_cycle;
  bit          steady     = 1'b0;
  logic [7:0]  maker_now  = 8'h01;
  logic [15:0] wait_now   = 16'd16;
  int          quiet      = 0;

  nor_flash_command_sequencer_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_transaction(in_tuser, in_tdata[31:0], in_tdata[63:32]);
      if (out_tvalid && out_tready) begin
        seen_cycle.kind   = out_tuser;
        seen_cycle.adr    = out_tdata[31:0];
        seen_cycle.dat    = out_tdata[63:32];
        seen_cycle.status = out_tdata[66:64];
        seen_cycle.dev    = out_tdata[71:67];
        seen_cycle.maker  = out_tdata[79:72];
        seen_cycle.mask   = out_tdata[83:80];
        seen_cycle.last   = out_tlast;
        sb.check_bus_cycle(seen_cycle);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: random back-pressure, plus one long hold-off to fill the job queue
  initial begin
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && sb.checked >= HOLD_AFTER) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_tready <= steady || ($urandom_range(0, 99) >= 26);
    end
  end

  task automatic send_item(input logic [2:0] op, input logic [31:0] adr,
                           input logic [31:0] dat);
    while (!steady && $urandom_range(0, 99) < 26) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {dat, adr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.due_cycles.size() != 0) @(posedge clk);
    repeat (32) @(posedge clk);
  endtask

  task automatic load_regs(input logic [31:0] base, input logic [7:0] mk,
                           input logic [15:0] bw);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FLASH_BASE;
    cfg_wdata <= base;
    @(posedge clk);
    sb.set_reg(CFG_FLASH_BASE, base);
    cfg_index <= CFG_MAKER_ID;
    cfg_wdata <= {24'h0, mk};
    @(posedge clk);
    sb.set_reg(CFG_MAKER_ID, {24'h0, mk});
    cfg_index <= CFG_BUS_WAIT;
    cfg_wdata <= {16'h0, bw};
    @(posedge clk);
    sb.set_reg(CFG_BUS_WAIT, {16'h0, bw});
    cfg_we    <= 1'b0;
    maker_now = mk;
    wait_now  = bw;
  endtask

  // status word: lanes ahead of the busy one already match DQ7
  function automatic logic [31:0] poll_word(input logic [31:0] pat, input poll_mode_t mode);
    logic [31:0] w;
    int          lane;
    int          k;
    w    = $urandom;
    lane = $urandom_range(0, 3);
    for (k = 0; k < 4; k++) begin
      if (mode == POLL_DONE || k < lane) begin
        w[8*k+7] = pat[8*k+7];
      end else if (k == lane) begin
        w[8*k+7] = ~pat[8*k+7];
        w[8*k+5] = (mode == POLL_FAIL);
      end
    end
    return w;
  endfunction

  function automatic logic [31:0] ident_word(input logic [7:0] mk, input ident_style_t style);
    logic [31:0] w;
    logic [3:0]  sel;
    int          k;
    w = {4{mk}};
    case (style)
      ID_FOREIGN: w = {4{mk ^ 8'($urandom_range(1, 255))}};
      ID_SPLIT: begin
        sel = 4'($urandom_range(1, 14));
        for (k = 0; k < 4; k++)
          if (sel[k]) w[8*k +: 8] = mk ^ 8'($urandom_range(1, 255));
      end
      ID_ABSENT: begin
        for (k = 0; k < 4; k++) w[8*k +: 8] = mk ^ 8'($urandom_range(1, 255));
        // force a disagreement without landing on the maker code
        if (w[7:0] == w[15:8])
          w[15:8] = ((w[7:0] ^ 8'h80) == mk) ? w[7:0] ^ 8'h40 : w[7:0] ^ 8'h80;
      end
      default: ;
    endcase
    return w;
  endfunction

  function automatic logic [31:0] device_word();
    logic [31:0] w;
    w = $urandom;
    if ($urandom_range(0, 99) < 65) w[7:0] = DEVICE_TYPE_CODES[$urandom_range(0, 17)];
    return w;
  endfunction

  task automatic run_random(input int n);
    int           sent;
    int           pick;
    int           polls;
    logic [2:0]   op;
    logic [31:0]  adr;
    logic [31:0]  dat;
    logic [31:0]  pat;
    poll_mode_t   mode;
    ident_style_t style;
    sent = 0;
    while (sent < n) begin
      adr = $urandom;
      dat = $urandom;
      if ($urandom_range(0, 99) < 82) begin
        op = 3'($urandom_range(0, 4));
        send_item(op, adr, dat);
        sent++;
        case (op)
          OP_PROG, OP_SECT, OP_CHIP: begin
            pat   = (op == OP_PROG) ? dat : D_80;
            mode  = POLL_BUSY;
            polls = 0;
            while (mode == POLL_BUSY && polls < 3) begin
              pick = $urandom_range(0, 99);
              if (pick < 45) mode = POLL_DONE;
              else if (pick < 75) mode = POLL_BUSY;
              else mode = POLL_FAIL;
              send_item(OP_READ, $urandom, poll_word(pat, mode));
              polls++;
              sent++;
            end
          end
          OP_IDENT: begin
            pick = $urandom_range(0, 99);
            if (pick < 50) style = ID_MATCH;
            else if (pick < 65) style = ID_FOREIGN;
            else if (pick < 83) style = ID_SPLIT;
            else style = ID_ABSENT;
            send_item(OP_READ, $urandom, ident_word(maker_now, style));
            sent++;
            if (style == ID_MATCH || style == ID_FOREIGN) begin
              send_item(OP_READ, $urandom, device_word());
              sent++;
            end
          end
          default: ;
        endcase
      end else begin
        op = 3'($urandom_range(0, 7));
        send_item(op, adr, dat);
        if (op <= OP_READ) sent++;
      end
    end
  endtask

  task automatic directed();
    send_item(OP_READ, 32'h0, 32'hFFFF_FFFF);
    send_item(OP_SPARE6, 32'hFFFF_FFFF, 32'h0);
    send_item(OP_SPARE7, 32'h1234_5678, 32'h8765_4321);
    send_item(OP_RESET, 32'h0, 32'h0);
    send_item(OP_PROG, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_READ, 32'h0, 32'hFFFF_FFFF);
    send_item(OP_PROG, 32'h0, 32'h0);
    send_item(OP_READ, 32'h0, 32'h0000_0080);
    send_item(OP_READ, 32'h0, 32'h0000_00A0);
    send_item(OP_SECT, 32'h1234_5678, 32'h0);
    send_item(OP_READ, 32'h0, D_80);
    send_item(OP_CHIP, 32'h0, 32'h0);
    send_item(OP_READ, 32'h0, 32'h2020_2020);
    // all lanes agree; code 0x00 must take the first of its two table entries
    send_item(OP_IDENT, 32'h0, 32'h0);
    send_item(OP_READ, 32'h0, 32'h0101_0101);
    send_item(OP_READ, 32'h0, 32'hFFFF_FF00);
    send_item(OP_IDENT, 32'h0, 32'h0);
    send_item(OP_READ, 32'h0, 32'h0202_0202);
    send_item(OP_READ, 32'h0, 32'h0000_00A2);
    send_item(OP_IDENT, 32'h0, 32'h0);
    send_item(OP_READ, 32'h0, 32'h0302_0100);
    send_item(OP_IDENT, 32'h0, 32'h0);
    send_item(OP_READ, 32'h0, 32'h0504_0302);
    // a new command abandons the program still being polled
    send_item(OP_PROG, 32'hABCD_0010, 32'h5A5A_5A5A);
    send_item(OP_IDENT, 32'h0, 32'h0);
    send_item(OP_READ, 32'h0, 32'h0101_0101);
    send_item(OP_READ, 32'h0, 32'h0000_00D5);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed();
    drain();
    load_regs(32'hFFFF_FFFF, 8'hFF, 16'd0);
    run_random(100);
    drain();
    load_regs($urandom, 8'h00, 16'($urandom_range(1, 6)));
    steady = 1'b1;
    run_random(50);
    steady = 1'b0;
    run_random(50);
    drain();
    // slowest bus pacing: keep this setting to a handful of transactions
    load_regs($urandom, 8'($urandom), 16'hFFFF);
    send_item(OP_RESET, $urandom, $urandom);
    send_item(OP_PROG, 32'h00C0_FFEE, 32'h7F80_01FE);
    send_item(OP_READ, $urandom, poll_word(32'h7F80_01FE, POLL_DONE));
    drain();
    load_regs($urandom, 8'($urandom), 16'd3);
    run_random(100);
    drain();
    repeat (8 * (wait_now + 1) + 40) @(posedge clk);
    if (sb.due_cycles.size() != 0)
      $error("%0d expected bus cycles never arrived", sb.due_cycles.size());
    $display("Checked %0d bus cycles from %0d input transactions over five register settings,",
             sb.checked, sb.inputs);
    $display("with ignored codes, abandoned commands, all poll outcomes and a long hold-off.");
    if (sb.errors == 0 && sb.due_cycles.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
